// ===== src/dmwbc_pkg.sv =====
package dmwbc_pkg;

  // Port widths fixed by the item format
  localparam int ADDR_PORT_BITS = 16;
  localparam int BYTE_BITS      = 8;
  localparam int LINE_PORT_BITS = 64;

  // Operation codes carried on the mode field
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_t;

endpackage

// ===== src/direct_mapped_writeback_cache_top.sv =====
// Direct-mapped write-back cache in front of a byte memory of 2^ADDR_BITS bytes,
// NUM_LINES lines of LINE_BYTES bytes (both powers of two). An address splits,
// from the top, into tag, line index and byte offset; bits of address above
// ADDR_BITS are ignored. A write item (mode 1) stores one byte and marks the line
// dirty; it returns nothing. A read item (mode 0) returns the whole line
// (byte 0 in bits 7..0, upper bits zero when lines are narrower than 64 bits),
// the hit flag, and the dirty mark as it was before the read. On a miss the
// victim line is written back and the addressed line filled first. Each item
// goes through a synchronous read of the line store and the backing store,
// both issued when the item is accepted, and then a lookup step to compare,
// merge and write both stores back. Only one item is in flight, so no two
// accesses to one entry overlap. A finished read result sits in an output
// register; the block accepts the next item while it waits and only holds a
// later read in its lookup step until the result is taken. After reset the
// block runs a clearing pass that zeroes the backing store and the line store;
// in_ready is low during it.
module direct_mapped_writeback_cache_top #(
  parameter int NUM_LINES  = 64,
  parameter int LINE_BYTES = 8,
  parameter int ADDR_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 mode,
  input  logic [dmwbc_pkg::ADDR_PORT_BITS-1:0] address,
  input  logic [dmwbc_pkg::BYTE_BITS-1:0]      write_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dmwbc_pkg::LINE_PORT_BITS-1:0] line_bytes,
  output logic                                 hit,
  output logic                                 dirty
);
  import dmwbc_pkg::*;

  localparam int OFF_BITS  = $clog2(LINE_BYTES);
  localparam int IDX_BITS  = $clog2(NUM_LINES);
  localparam int TAG_BITS  = ADDR_BITS - OFF_BITS - IDX_BITS;
  localparam int MIDX_BITS = ADDR_BITS - OFF_BITS;     // backing store line address
  localparam int MEM_LINES = (1 << ADDR_BITS) / LINE_BYTES;
  localparam int DATA_BITS = LINE_BYTES * BYTE_BITS;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic                 dirty;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  // Line store and backing store
  entry_t               cache_mem [NUM_LINES];
  logic [DATA_BITS-1:0] backing_mem [MEM_LINES];

  state_t state, state_next;
  logic [MIDX_BITS-1:0] clr_cnt;

  // Address split of the incoming item
  logic [ADDR_BITS-1:0] addr_w;
  logic [IDX_BITS-1:0]  idx_in;
  logic [MIDX_BITS-1:0] fill_in;
  logic                 accept;

  // Item held for the lookup state
  logic                 mode_q;
  logic [TAG_BITS-1:0]  tag_q;
  logic [IDX_BITS-1:0]  idx_q;
  logic [OFF_BITS-1:0]  off_q;
  logic [BYTE_BITS-1:0] byte_q;

  // Registered read data
  entry_t               ent_rd;
  logic [DATA_BITS-1:0] fill_rd;

  // Lookup / merge
  logic                 is_hit;
  logic                 advance;
  logic [DATA_BITS-1:0] base_data;
  entry_t               ent_new;

  // Write ports
  logic                 cache_we;
  logic [IDX_BITS-1:0]  cache_waddr;
  entry_t               cache_wdata;
  logic                 mem_we;
  logic [MIDX_BITS-1:0] mem_waddr;
  logic [DATA_BITS-1:0] mem_wdata;

  assign addr_w   = ADDR_BITS'(address);
  assign idx_in   = addr_w[OFF_BITS +: IDX_BITS];
  assign fill_in  = addr_w[ADDR_BITS-1:OFF_BITS];
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Merge: on a miss the filled line replaces the victim; a write then
  // patches one byte and marks the line dirty, a read miss comes back clean.
  always_comb begin
    is_hit    = (ent_rd.tag == tag_q);
    base_data = is_hit ? ent_rd.data : fill_rd;
    ent_new.tag  = tag_q;
    ent_new.data = base_data;
    if (mode_q == MODE_WRITE) begin
      ent_new.data[{off_q, 3'b000} +: BYTE_BITS] = byte_q;
      ent_new.dirty = 1'b1;
    end else begin
      ent_new.dirty = is_hit ? ent_rd.dirty : 1'b0;
    end
  end

  // A read only finishes once the output register is free
  assign advance = (state == ST_LOOKUP) &&
                   ((mode_q == MODE_WRITE) || !out_valid || out_ready);

  always_comb begin
    if (state == ST_CLEAR) begin
      cache_we    = 1'b1;
      cache_waddr = clr_cnt[IDX_BITS-1:0];
      cache_wdata = '0;
      mem_we      = 1'b1;
      mem_waddr   = clr_cnt;
      mem_wdata   = '0;
    end else begin
      cache_we    = advance;
      cache_waddr = idx_q;
      cache_wdata = ent_new;
      mem_we      = advance && !is_hit;        // victim writeback
      mem_waddr   = {ent_rd.tag, idx_q};
      mem_wdata   = ent_rd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_waddr] <= cache_wdata;
    end
    if (accept) begin
      ent_rd <= cache_mem[idx_in];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      backing_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      fill_rd <= backing_mem[fill_in];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      tag_q  <= addr_w[ADDR_BITS-1 -: TAG_BITS];
      idx_q  <= idx_in;
      off_q  <= addr_w[OFF_BITS-1:0];
      byte_q <= write_byte;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == {MIDX_BITS{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (mode_q == MODE_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (mode_q == MODE_READ)) begin
      line_bytes <= LINE_PORT_BITS'(base_data);
      hit        <= is_hit;
      dirty      <= ent_rd.dirty;
    end
  end

endmodule
